// File: hw/rtl/dual_token_bucket_policer_core_macros.svh
// assertion macros shared by the policer core modules
`ifndef DUAL_TOKEN_BUCKET_POLICER_CORE_MACROS_SVH
`define DUAL_TOKEN_BUCKET_POLICER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTBP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtbp assertion failed");
`define DTBP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtbp assertion failed");
`else
`define DTBP_ASSERT_IMP(name, clk, rst, ante, cons)
`define DTBP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/dtbp_pkg.sv
// types, constants and codes shared by the policer core modules
package dtbp_pkg;

   localparam int PEER_SLOTS = 4096;
   localparam int PEER_AW    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 12;
   localparam int BYTES_W    = 24;
   localparam int TIME_W     = 48;
   localparam int KBPS_W     = 20;
   localparam int REQ_DATA_W = ((CMD_W + INDEX_W + BYTES_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CMD_W-1:0] CMD_PEER_PKT     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PEER_BYTES   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GLOBAL_BYTES = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_PEER_KBPS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_GLOBAL_KBPS = 1'b1;

   localparam logic [KBPS_W-1:0] PEER_KBPS_RESET   = 20'd64;
   localparam logic [KBPS_W-1:0] GLOBAL_KBPS_RESET = 20'd1024;

   localparam int PKT_RATE  = 32;
   localparam int GPKT_RATE = 256;
   localparam int KIB       = 1024;
   localparam int MS_PER_S  = 1000;
   localparam int RATE_UNIT = 8;
   localparam int DIV_CONST = MS_PER_S / RATE_UNIT;
   localparam int PKT_CAP   = 2 * PKT_RATE;
   localparam int GPKT_CAP  = 2 * GPKT_RATE;

   localparam int SHIFT_W    = 3;
   localparam int PKT_SHIFT  = $clog2(PKT_RATE / RATE_UNIT);
   localparam int GPKT_SHIFT = $clog2(GPKT_RATE / RATE_UNIT);
   localparam int BYTE_SHIFT = $clog2(KIB / RATE_UNIT);
   localparam int CAP_SHIFT  = $clog2(KIB) + 1;

   localparam int PTOK_W  = 7;
   localparam int GPTOK_W = 10;
   localparam int BTOK_W  = 32;
   localparam int TOK_W   = 34;
   localparam int ROOM_W  = 32;

   // elapsed beyond this always refills to the cap
   localparam int EL_W   = 41;
   localparam int EL_LO  = 21;
   localparam int NUM_W  = EL_W + KBPS_W + BYTE_SHIFT;
   localparam int DIV_W  = 38;

   // rounded-up reciprocal of the divisor, exact for dividends below 2**DIV_W
   localparam int RCP_SH = DIV_W + $clog2(DIV_CONST);
   localparam int RCP_W  = DIV_W + 1;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SH) + 64'(DIV_CONST) - 64'd1) / 64'(DIV_CONST));

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
   localparam logic [OP_W-1:0] OP_FETCH  = 3'd3;
   localparam logic [OP_W-1:0] OP_START  = 3'd4;
   localparam logic [OP_W-1:0] OP_SETTLE = 3'd5;
   localparam logic [OP_W-1:0] OP_COMMIT = 3'd6;

   localparam logic [1:0] BKT_PP = 2'd0;
   localparam logic [1:0] BKT_GP = 2'd1;
   localparam logic [1:0] BKT_PB = 2'd2;
   localparam logic [1:0] BKT_GB = 2'd3;

   typedef struct packed {
      logic [PTOK_W-1:0] ptok;
      logic [TIME_W-1:0] pstamp;
      logic [BTOK_W-1:0] btok;
      logic [TIME_W-1:0] bstamp;
   } peer_entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      sel;
   } dp_cmd_type;

   typedef struct packed {
      logic             clear_last;
      logic             pre_ok;
      logic [CMD_W-1:0] cmd;
      logic             refill_busy;
      logic             pass;
   } dp_status_type;

endpackage

// File: hw/rtl/dual_token_bucket_policer_core.sv
// top level of the dual token bucket admission policer
// Each request transaction yields one response transaction whose bit 0 says
// whether the request was admitted. After reset all PEER_SLOTS (4096) entries
// of the peer table are swept to zero with req_tready low; csr writes are
// taken throughout. A request is loaded, its peer entry read and fetched
// with a precheck; each bucket checked is then started, waits on one pass
// through the shared refill unit (the split product, the cap compare and a
// four-step reciprocal multiply for the divide by 125; a bucket needing no
// refill skips the unit) and is settled; a commit ends the request.
// Packet-with-bytes requests check four buckets, peer byte requests two,
// global byte requests one; a request failing the precheck or an early bucket
// ends sooner. Results sit in an output register, so the next request is
// taken while a response waits.
module dual_token_bucket_policer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd, peer_index, byte_count, now_ms (from bit 0), zero padded
   input  logic [dtbp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // allowed (bit 0), zero padded
   output logic [dtbp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [dtbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dtbp_pkg::KBPS_W-1:0]         csr_wdata
);
   import dtbp_pkg::*;

   localparam int IDX_LSB   = CMD_W;
   localparam int BYTES_LSB = IDX_LSB + INDEX_W;
   localparam int TIME_LSB  = BYTES_LSB + BYTES_W;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          allowed;

   dtbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_allowed (allowed),
      .dp_cmd      (dp_cmd),
      .status      (dp_status)
   );

   dtbp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_tdata[CMD_W-1:0]),
      .req_peer_index (req_tdata[BYTES_LSB-1:IDX_LSB]),
      .req_byte_count (req_tdata[TIME_LSB-1:BYTES_LSB]),
      .req_now_ms     (req_tdata[TIME_LSB+TIME_W-1:TIME_LSB]),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status)
   );

   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, allowed};
endmodule

// File: hw/rtl/dtbp_refill.sv
// refill unit: tokens earned over elapsed time, capped at the room left
`include "dual_token_bucket_policer_core_macros.svh"
module dtbp_refill (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dtbp_pkg::TIME_W-1:0]    elapsed,
   input  logic [dtbp_pkg::KBPS_W-1:0]    k,
   input  logic [dtbp_pkg::SHIFT_W-1:0]   shift,
   input  logic [dtbp_pkg::ROOM_W-1:0]    room,
   output logic                           busy,
   output logic [dtbp_pkg::ROOM_W-1:0]    add
);
   import dtbp_pkg::*;

   localparam logic [2:0] PH_MUL_LO = 3'd0;
   localparam logic [2:0] PH_MUL_HI = 3'd1;
   localparam logic [2:0] PH_SUM    = 3'd2;
   localparam logic [2:0] PH_CMP    = 3'd3;
   localparam logic [2:0] PH_DIV    = 3'd4;

   localparam int EL_HI    = EL_W - EL_LO;
   localparam int PLO_W    = EL_LO + KBPS_W;
   localparam int PHI_W    = EL_HI + KBPS_W;
   localparam int PROD_W   = EL_W + KBPS_W;
   localparam int ITERS    = 4;
   localparam int CNT_W    = 2;
   localparam int R125_W   = ROOM_W + 7;
   localparam int HALF_W   = DIV_W / 2;
   localparam int PP_W     = 2 * HALF_W + 1;
   localparam int ACC_W    = DIV_W + RCP_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);
   localparam logic [HALF_W:0]  RCP_LO   = (HALF_W+1)'(RCP[HALF_W-1:0]);
   localparam logic [HALF_W:0]  RCP_HI   = RCP[RCP_W-1:HALF_W];

   logic                  busy_ff, busy_in;
   logic [2:0]            phase_ff, phase_in;
   logic [EL_W-1:0]       el_ff, el_in;
   logic [KBPS_W-1:0]     k_ff, k_in;
   logic [SHIFT_W-1:0]    sh_ff, sh_in;
   logic [ROOM_W-1:0]     room_ff, room_in;
   logic [R125_W-1:0]     r125_ff, r125_in;
   logic [PLO_W-1:0]      plo_ff, plo_in;
   logic [PHI_W-1:0]      phi_ff, phi_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIV_W-1:0]      num_ff, num_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ROOM_W-1:0]     add_ff, add_in;
   logic [NUM_W-1:0]      scaled;
   logic [HALF_W-1:0]     pp_a;
   logic [HALF_W:0]       pp_b;
   logic [PP_W-1:0]       pp;
   logic [ACC_W-1:0]      acc_sum;

   // quotient by 125 as four partial products of the reciprocal
   always_comb begin
      scaled  = NUM_W'(prod_ff) << sh_ff;
      pp_a    = cnt_ff[1] ? num_ff[DIV_W-1:HALF_W] : num_ff[HALF_W-1:0];
      pp_b    = cnt_ff[0] ? RCP_HI : RCP_LO;
      pp      = PP_W'(pp_a) * PP_W'(pp_b);
      acc_sum = acc_ff + ((ACC_W'(pp) << (cnt_ff[1] ? HALF_W : 0))
                                      << (cnt_ff[0] ? HALF_W : 0));
   end

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      el_in    = el_ff;
      k_in     = k_ff;
      sh_in    = sh_ff;
      room_in  = room_ff;
      r125_in  = r125_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      add_in   = add_ff;
      if (start) begin
         el_in   = elapsed[EL_W-1:0];
         k_in    = k;
         sh_in   = shift;
         room_in = room;
         if (elapsed[TIME_W-1:EL_W] != '0) begin
            add_in = room;
         end else begin
            busy_in  = 1'b1;
            phase_in = PH_MUL_LO;
         end
      end else if (busy_ff) begin
         case (phase_ff)
            PH_MUL_LO: begin
               plo_in   = PLO_W'(el_ff[EL_LO-1:0]) * PLO_W'(k_ff);
               r125_in  = R125_W'(room_ff) * R125_W'(DIV_CONST);
               phase_in = PH_MUL_HI;
            end
            PH_MUL_HI: begin
               phi_in   = PHI_W'(el_ff[EL_W-1:EL_LO]) * PHI_W'(k_ff);
               phase_in = PH_SUM;
            end
            PH_SUM: begin
               prod_in  = PROD_W'(plo_ff) + (PROD_W'(phi_ff) << EL_LO);
               phase_in = PH_CMP;
            end
            PH_CMP: begin
               if (scaled > NUM_W'(r125_ff)) begin
                  add_in  = room_ff;
                  busy_in = 1'b0;
               end else begin
                  num_in   = scaled[DIV_W-1:0];
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_DIV;
               end
            end
            PH_DIV: begin
               acc_in = acc_sum;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  add_in  = acc_sum[RCP_SH +: ROOM_W];
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_MUL_LO;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      el_ff   <= el_in;
      k_ff    <= k_in;
      sh_ff   <= sh_in;
      room_ff <= room_in;
      r125_ff <= r125_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      acc_ff  <= acc_in;
      add_ff  <= add_in;
   end

   assign busy = busy_ff;
   assign add  = add_ff;

   `DTBP_ASSERT_IMP(a_no_restart, clock, reset, start, !busy_ff)
   `DTBP_ASSERT_IMP(a_add_in_room, clock, reset, !busy_ff && $past(busy_ff), add_ff <= room_ff)
   `DTBP_ASSERT_NEXT(a_div_ends, clock, reset, busy_ff && phase_ff == PH_DIV && cnt_ff == CNT_LAST, !busy_ff)
endmodule

// File: hw/rtl/dtbp_datapath.sv
// datapath: peer table, global buckets, bucket arithmetic and commit
module dtbp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [dtbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtbp_pkg::KBPS_W-1:0]      csr_wdata,
   input  logic [dtbp_pkg::CMD_W-1:0]       req_cmd,
   input  logic [dtbp_pkg::INDEX_W-1:0]     req_peer_index,
   input  logic [dtbp_pkg::BYTES_W-1:0]     req_byte_count,
   input  logic [dtbp_pkg::TIME_W-1:0]      req_now_ms,
   input  dtbp_pkg::dp_cmd_type             dp_cmd,
   output dtbp_pkg::dp_status_type          dp_status
);
   import dtbp_pkg::*;

   peer_entry_type mem [PEER_SLOTS];
   peer_entry_type rd_ff;
   logic           mem_we;
   logic [PEER_AW-1:0] mem_waddr;
   peer_entry_type mem_wdata;

   logic [KBPS_W-1:0]  peer_kbps_ff, global_kbps_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [PEER_AW-1:0] clr_ff;

   logic [GPTOK_W-1:0] gptok_ff;
   logic [TIME_W-1:0]  gpstamp_ff;
   logic [BTOK_W-1:0]  gbtok_ff;
   logic [TIME_W-1:0]  gbstamp_ff;

   logic [PTOK_W-1:0]  sh_ptok_ff;
   logic [TIME_W-1:0]  sh_pstamp_ff;
   logic [BTOK_W-1:0]  sh_btok_ff;
   logic [TIME_W-1:0]  sh_bstamp_ff;
   logic [GPTOK_W-1:0] sh_gptok_ff;
   logic [TIME_W-1:0]  sh_gpstamp_ff;
   logic [BTOK_W-1:0]  sh_gbtok_ff;
   logic [TIME_W-1:0]  sh_gbstamp_ff;

   logic [TOK_W-1:0]   cur_tok_ff, cur_tok_in;
   logic [TIME_W-1:0]  cur_stamp_ff, cur_stamp_in;
   logic               add_use_ff, add_use_in;

   logic [TOK_W-1:0]   sel_tok, sel_cap, sel_amt, held, room_full, total, new_tok;
   logic [TIME_W-1:0]  sel_stamp, elapsed;
   logic [KBPS_W-1:0]  sel_k;
   logic [SHIFT_W-1:0] sel_shift;
   logic               stamp_zero, later, refill_start, refill_busy, pre_ok;
   logic [ROOM_W-1:0]  refill_add;
   logic [TOK_W-1:0]   pcap, gcap, bytes_ext;

   assign pcap      = TOK_W'(peer_kbps_ff) << CAP_SHIFT;
   assign gcap      = TOK_W'(global_kbps_ff) << CAP_SHIFT;
   assign bytes_ext = TOK_W'(bytes_ff);

   always_comb begin
      case (cmd_ff)
         CMD_PEER_PKT, CMD_PEER_BYTES: begin
            pre_ok = (peer_kbps_ff != '0) && (global_kbps_ff != '0) &&
                     (bytes_ext <= pcap) && (bytes_ext <= gcap) &&
                     (32'(idx_ff) < PEER_SLOTS);
         end
         CMD_GLOBAL_BYTES: begin
            pre_ok = (global_kbps_ff != '0) && (bytes_ext <= gcap);
         end
         default: begin
            pre_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (dp_cmd.sel)
         BKT_PP: begin
            sel_tok   = TOK_W'(rd_ff.ptok);
            sel_stamp = rd_ff.pstamp;
            sel_cap   = TOK_W'(PKT_CAP);
            sel_amt   = TOK_W'(1);
            sel_k     = KBPS_W'(1);
            sel_shift = SHIFT_W'(PKT_SHIFT);
         end
         BKT_GP: begin
            sel_tok   = TOK_W'(gptok_ff);
            sel_stamp = gpstamp_ff;
            sel_cap   = TOK_W'(GPKT_CAP);
            sel_amt   = TOK_W'(1);
            sel_k     = KBPS_W'(1);
            sel_shift = SHIFT_W'(GPKT_SHIFT);
         end
         BKT_PB: begin
            sel_tok   = TOK_W'(rd_ff.btok);
            sel_stamp = rd_ff.bstamp;
            sel_cap   = pcap;
            sel_amt   = bytes_ext;
            sel_k     = peer_kbps_ff;
            sel_shift = SHIFT_W'(BYTE_SHIFT);
         end
         default: begin
            sel_tok   = TOK_W'(gbtok_ff);
            sel_stamp = gbstamp_ff;
            sel_cap   = gcap;
            sel_amt   = bytes_ext;
            sel_k     = global_kbps_ff;
            sel_shift = SHIFT_W'(BYTE_SHIFT);
         end
      endcase
   end

   always_comb begin
      held         = (sel_tok < sel_cap) ? sel_tok : sel_cap;
      room_full    = sel_cap - held;
      elapsed      = now_ff - sel_stamp;
      stamp_zero   = (sel_stamp == '0);
      later        = (now_ff > sel_stamp);
      refill_start = (dp_cmd.op == OP_START) && !stamp_zero && later;
      total        = cur_tok_ff + (add_use_ff ? TOK_W'(refill_add) : '0);
      new_tok      = total - sel_amt;
   end

   always_comb begin
      cur_tok_in   = cur_tok_ff;
      cur_stamp_in = cur_stamp_ff;
      add_use_in   = add_use_ff;
      if (dp_cmd.op == OP_START) begin
         cur_tok_in   = stamp_zero ? sel_cap : sel_tok;
         cur_stamp_in = (stamp_zero || later) ? now_ff : sel_stamp;
         add_use_in   = refill_start;
      end
   end

   dtbp_refill u_refill (
      .clock   (clock),
      .reset   (reset),
      .start   (refill_start),
      .elapsed (elapsed),
      .k       (sel_k),
      .shift   (sel_shift),
      .room    (room_full[ROOM_W-1:0]),
      .busy    (refill_busy),
      .add     (refill_add)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (dp_cmd.op == OP_CLEAR) begin
         mem_we = 1'b1;
      end else if (dp_cmd.op == OP_COMMIT && cmd_ff != CMD_GLOBAL_BYTES) begin
         mem_we    = 1'b1;
         mem_waddr = PEER_AW'(idx_ff);
         mem_wdata = '{ptok: sh_ptok_ff, pstamp: sh_pstamp_ff,
                        btok: sh_btok_ff, bstamp: sh_bstamp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[PEER_AW'(idx_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_kbps_ff   <= PEER_KBPS_RESET;
         global_kbps_ff <= GLOBAL_KBPS_RESET;
         clr_ff         <= '0;
         gptok_ff       <= '0;
         gpstamp_ff     <= '0;
         gbtok_ff       <= '0;
         gbstamp_ff     <= '0;
      end else begin
         if (csr_wen && csr_index == REG_PEER_KBPS) begin
            peer_kbps_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == REG_GLOBAL_KBPS) begin
            global_kbps_ff <= csr_wdata;
         end
         if (dp_cmd.op == OP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (dp_cmd.op == OP_COMMIT) begin
            gptok_ff   <= sh_gptok_ff;
            gpstamp_ff <= sh_gpstamp_ff;
            gbtok_ff   <= sh_gbtok_ff;
            gbstamp_ff <= sh_gbstamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_tok_ff   <= cur_tok_in;
      cur_stamp_ff <= cur_stamp_in;
      add_use_ff   <= add_use_in;
      if (dp_cmd.op == OP_LOAD) begin
         cmd_ff   <= req_cmd;
         idx_ff   <= req_peer_index;
         bytes_ff <= req_byte_count;
         now_ff   <= req_now_ms;
      end
      if (dp_cmd.op == OP_FETCH) begin
         sh_ptok_ff    <= rd_ff.ptok;
         sh_pstamp_ff  <= rd_ff.pstamp;
         sh_btok_ff    <= rd_ff.btok;
         sh_bstamp_ff  <= rd_ff.bstamp;
         sh_gptok_ff   <= gptok_ff;
         sh_gpstamp_ff <= gpstamp_ff;
         sh_gbtok_ff   <= gbtok_ff;
         sh_gbstamp_ff <= gbstamp_ff;
      end
      if (dp_cmd.op == OP_SETTLE) begin
         case (dp_cmd.sel)
            BKT_PP: begin
               sh_ptok_ff   <= new_tok[PTOK_W-1:0];
               sh_pstamp_ff <= cur_stamp_ff;
            end
            BKT_GP: begin
               sh_gptok_ff   <= new_tok[GPTOK_W-1:0];
               sh_gpstamp_ff <= cur_stamp_ff;
            end
            BKT_PB: begin
               sh_btok_ff   <= new_tok[BTOK_W-1:0];
               sh_bstamp_ff <= cur_stamp_ff;
            end
            default: begin
               sh_gbtok_ff   <= new_tok[BTOK_W-1:0];
               sh_gbstamp_ff <= cur_stamp_ff;
            end
         endcase
      end
   end

   assign dp_status = '{clear_last:  (clr_ff == PEER_AW'(PEER_SLOTS - 1)),
                        pre_ok:      pre_ok,
                        cmd:         cmd_ff,
                        refill_busy: refill_busy,
                        pass:        (total >= sel_amt)};
endmodule

// File: hw/rtl/dtbp_ctrl.sv
// controller: sequences table clear, bucket checks, commit and response
`include "dual_token_bucket_policer_core_macros.svh"
module dtbp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_allowed,
   output dtbp_pkg::dp_cmd_type    dp_cmd,
   input  dtbp_pkg::dp_status_type status
);
   import dtbp_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_START  = 3'd4;
   localparam logic [2:0] ST_WAIT   = 3'd5;
   localparam logic [2:0] ST_SETTLE = 3'd6;
   localparam logic [2:0] ST_COMMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       dec_ff, dec_in;
   logic       resp_ff, resp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_allowed_ff, rsp_allowed_in;
   logic [OP_W-1:0] op;

   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      dec_in         = dec_ff;
      resp_in        = resp_ff;
      op             = OP_NONE;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_allowed_in = rsp_allowed_ff;
      if (resp_ff && !rsp_valid_in) begin
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = dec_ff;
         resp_in        = 1'b0;
         state_in       = ST_IDLE;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               op = OP_CLEAR;
               if (status.clear_last) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  op       = OP_LOAD;
                  state_in = ST_READ;
               end
            end
            ST_READ: begin
               state_in = ST_FETCH;
            end
            ST_FETCH: begin
               op = OP_FETCH;
               if (!status.pre_ok) begin
                  dec_in  = 1'b0;
                  resp_in = 1'b1;
               end else begin
                  case (status.cmd)
                     CMD_PEER_PKT:   sel_in = BKT_PP;
                     CMD_PEER_BYTES: sel_in = BKT_PB;
                     default:        sel_in = BKT_GB;
                  endcase
                  state_in = ST_START;
               end
            end
            ST_START: begin
               op       = OP_START;
               state_in = ST_WAIT;
            end
            ST_WAIT: begin
               if (!status.refill_busy) begin
                  state_in = ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               op = OP_SETTLE;
               if (!status.pass) begin
                  dec_in  = 1'b0;
                  resp_in = 1'b1;
               end else if (sel_ff == BKT_GB) begin
                  state_in = ST_COMMIT;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_START;
               end
            end
            ST_COMMIT: begin
               op      = OP_COMMIT;
               dec_in  = 1'b1;
               resp_in = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sel_ff       <= BKT_PP;
         dec_ff       <= 1'b0;
         resp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         dec_ff       <= dec_in;
         resp_ff      <= resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_allowed_ff <= rsp_allowed_in;
   end

   assign req_tready  = (state_ff == ST_IDLE) && !resp_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign dp_cmd      = '{op: op, sel: sel_ff};

   `DTBP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `DTBP_ASSERT_IMP(a_settle_after_refill, clock, reset, state_ff == ST_SETTLE, !status.refill_busy)
   `DTBP_ASSERT_IMP(a_idle_unit_quiet, clock, reset, state_ff == ST_IDLE, !status.refill_busy)
endmodule

// File: tb/sv/dtbp_admission_checker.sv
// admission checker for the dual token bucket policer: predicts and compares responses
module dtbp_admission_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [dtbp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [dtbp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wen,
   input  logic [dtbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtbp_pkg::KBPS_W-1:0]      csr_wdata,
   output int                               fail_count,
   output int                               pending,
   output int                               grant_count,
   output int                               deny_count
);
   import dtbp_pkg::*;

   typedef struct {
      longint unsigned tokens;
      longint unsigned stamp;
   } bucket_t;

   localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
   localparam int RING_DEPTH = 16;

   longint unsigned peer_rate_kbps, global_rate_kbps;
   bit              slot_valid [PEER_SLOTS];
   longint unsigned slot_pkt_tok [PEER_SLOTS];
   longint unsigned slot_pkt_stamp [PEER_SLOTS];
   longint unsigned slot_byte_tok [PEER_SLOTS];
   longint unsigned slot_byte_stamp [PEER_SLOTS];
   longint unsigned all_pkt_tok, all_pkt_stamp, all_byte_tok, all_byte_stamp;
   bit              admit_ring [RING_DEPTH];
   int              ring_wr, ring_rd;

   function automatic bit refill_take(inout bucket_t b, input longint unsigned amount,
                                      input longint unsigned rate, input longint unsigned cap,
                                      input longint unsigned now);
      longint unsigned elapsed, held, room, add;
      if (rate == 0 || cap == 0 || amount > cap) return 1'b0;
      if (b.stamp == 0) begin
         b.tokens = cap;
         b.stamp  = now;
      end else if (now > b.stamp) begin
         elapsed = now - b.stamp;
         held    = (b.tokens < cap) ? b.tokens : cap;
         room    = cap - held;
         if (elapsed > (room * 1000) / rate) add = room;
         else begin
            add = (elapsed * rate) / 1000;
            if (add > room) add = room;
         end
         b.tokens += add;
         b.stamp = now;
      end
      if (b.tokens < amount) return 1'b0;
      b.tokens -= amount;
      return 1'b1;
   endfunction

   function automatic bit predict_admit(logic [REQ_DATA_W-1:0] d);
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] slot;
      longint unsigned    bytes, now, prate, grate;
      bucket_t            pp, pb, gp, gb;
      cmd   = d[CMD_W-1:0];
      slot  = d[CMD_W +: INDEX_W];
      bytes = d[CMD_W+INDEX_W +: BYTES_W];
      now   = d[CMD_W+INDEX_W+BYTES_W +: TIME_W];
      prate = peer_rate_kbps * 1024;
      grate = global_rate_kbps * 1024;
      gb.tokens = all_byte_tok;
      gb.stamp  = all_byte_stamp;
      if (cmd == CMD_GLOBAL_BYTES) begin
         if (!refill_take(gb, bytes, grate, grate * 2, now)) return 1'b0;
         all_byte_tok   = gb.tokens & 64'hFFFF_FFFF;
         all_byte_stamp = gb.stamp & MASK48;
         return 1'b1;
      end
      if (cmd != CMD_PEER_PKT && cmd != CMD_PEER_BYTES) return 1'b0;
      if (prate == 0 || grate == 0 || bytes > prate * 2 || bytes > grate * 2) return 1'b0;
      if (slot_valid[slot]) begin
         pp.tokens = slot_pkt_tok[slot];  pp.stamp = slot_pkt_stamp[slot];
         pb.tokens = slot_byte_tok[slot]; pb.stamp = slot_byte_stamp[slot];
      end else begin
         pp.tokens = 0; pp.stamp = 0; pb.tokens = 0; pb.stamp = 0;
      end
      gp.tokens = all_pkt_tok;
      gp.stamp  = all_pkt_stamp;
      if (cmd == CMD_PEER_PKT) begin
         if (!refill_take(pp, 1, PKT_RATE, PKT_CAP, now)) return 1'b0;
         if (!refill_take(gp, 1, GPKT_RATE, GPKT_CAP, now)) return 1'b0;
      end
      if (!refill_take(pb, bytes, prate, prate * 2, now)) return 1'b0;
      if (!refill_take(gb, bytes, grate, grate * 2, now)) return 1'b0;
      slot_valid[slot]      = 1'b1;
      slot_pkt_tok[slot]    = pp.tokens & 64'h7F;
      slot_pkt_stamp[slot]  = pp.stamp & MASK48;
      slot_byte_tok[slot]   = pb.tokens & 64'hFFFF_FFFF;
      slot_byte_stamp[slot] = pb.stamp & MASK48;
      all_pkt_tok    = gp.tokens & 64'h3FF;
      all_pkt_stamp  = gp.stamp & MASK48;
      all_byte_tok   = gb.tokens & 64'hFFFF_FFFF;
      all_byte_stamp = gb.stamp & MASK48;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         peer_rate_kbps   = PEER_KBPS_RESET;
         global_rate_kbps = GLOBAL_KBPS_RESET;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         all_pkt_tok = 0; all_pkt_stamp = 0; all_byte_tok = 0; all_byte_stamp = 0;
         ring_wr = 0; ring_rd = 0;
         fail_count = 0; pending = 0; grant_count = 0; deny_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (ring_wr == ring_rd) begin
               $display("%0t: response transaction with none expected, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = admit_ring[ring_rd % RING_DEPTH];
               ring_rd++;
               if (rsp_tdata[0] !== want) begin
                  $display("%0t: allowed mismatch, expected %0d actual %0d",
                           $time, want, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:1] !== '0) begin
                  $display("%0t: response padding mismatch, expected 0 actual %h",
                           $time, rsp_tdata[RSP_DATA_W-1:1]);
                  fail_count++;
               end
            end
         end
         if (csr_wen) begin
            if (csr_index == REG_PEER_KBPS) peer_rate_kbps = csr_wdata;
            else if (csr_index == REG_GLOBAL_KBPS) global_rate_kbps = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            want = predict_admit(req_tdata);
            admit_ring[ring_wr % RING_DEPTH] = want;
            ring_wr++;
            if (want) grant_count++;
            else deny_count++;
         end
         pending = ring_wr - ring_rd;
      end
   end

endmodule

// File: tb/sv/testbench.sv
// testbench top: stimulus, rate settings and verdict for the policer core
module testbench;
   import dtbp_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [KBPS_W-1:0]      csr_wdata = '0;
   int                     fail_count, pending, grant_count, deny_count;
   bit                     steady = 1'b0;
   longint unsigned        clock_ms = 1;

   dual_token_bucket_policer_core u_top (.*);

   dtbp_admission_checker u_checker (.*);

   initial forever #1 clock = ~clock;

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 23);

   function automatic logic [REQ_DATA_W-1:0] pack_req(logic [CMD_W-1:0] cmd,
      logic [INDEX_W-1:0] slot, logic [BYTES_W-1:0] bytes, logic [TIME_W-1:0] now);
      return REQ_DATA_W'({now, bytes, slot, cmd});
   endfunction

   task automatic send_req(logic [REQ_DATA_W-1:0] d);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      if (!steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_rates(logic [KBPS_W-1:0] peer_kbps, logic [KBPS_W-1:0] global_kbps);
      csr_wen   <= 1'b1;
      csr_index <= REG_PEER_KBPS;
      csr_wdata <= peer_kbps;
      @(posedge clock);
      csr_index <= REG_GLOBAL_KBPS;
      csr_wdata <= global_kbps;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic random_req();
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] slot;
      logic [BYTES_W-1:0] bytes;
      int                 pick;
      pick = $urandom_range(99);
      cmd  = (pick < 40) ? CMD_PEER_PKT : (pick < 65) ? CMD_PEER_BYTES :
             (pick < 92) ? CMD_GLOBAL_BYTES : CMD_UNUSED;
      slot = ($urandom_range(9) < 8) ? INDEX_W'($urandom_range(7)) : INDEX_W'($urandom);
      pick = $urandom_range(99);
      bytes = (pick < 50) ? BYTES_W'($urandom_range(2000)) :
              (pick < 80) ? BYTES_W'($urandom_range(140000)) : BYTES_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) clock_ms += $urandom_range(3);
      else if (pick < 88) clock_ms += $urandom_range(2000);
      else if (pick < 94 && clock_ms > 50) clock_ms -= $urandom_range(50);
      else if (pick < 96) clock_ms = 0;
      else clock_ms = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
      clock_ms &= 64'hFFFF_FFFF_FFFF;
      send_req(pack_req(cmd, slot, bytes, clock_ms[TIME_W-1:0]));
   endtask

   initial begin
      logic [KBPS_W-1:0] peer_set [7];
      logic [KBPS_W-1:0] global_set [7];
      peer_set   = '{PEER_KBPS_RESET, 20'd1, 20'hFFFFF, 20'd0, 20'd64, 20'd16, 20'd0};
      global_set = '{GLOBAL_KBPS_RESET, 20'd1, 20'hFFFFF, 20'd1024, 20'd0, 20'd8, 20'd0};
      peer_set[6]   = 20'($urandom_range(1, 4096));
      global_set[6] = 20'($urandom_range(1, 4096));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero time, caps, precheck, time going back, unused command
      send_req(pack_req(CMD_PEER_PKT, 12'd0, 24'd100, 48'd0));
      send_req(pack_req(CMD_PEER_PKT, 12'd0, 24'd100, 48'd0));
      send_req(pack_req(CMD_GLOBAL_BYTES, 12'hFFF, 24'd0, 48'd5));
      send_req(pack_req(CMD_PEER_BYTES, 12'hFFF, 24'hFFFFFF, 48'd10));
      send_req(pack_req(CMD_UNUSED, 12'hABC, 24'h5A5A5A, 48'hA5A5_A5A5_A5A5));
      send_req(pack_req(CMD_PEER_PKT, 12'd1, 24'd131072, 48'd20));
      send_req(pack_req(CMD_PEER_PKT, 12'd1, 24'd1, 48'd21));
      send_req(pack_req(CMD_PEER_BYTES, 12'd1, 24'd1000, 48'd15));
      send_req(pack_req(CMD_PEER_BYTES, 12'd1, 24'd65536, 48'd1021));
      send_req(pack_req(CMD_PEER_BYTES, 12'hFFF, 24'd131073, 48'd1030));
      send_req(pack_req(CMD_GLOBAL_BYTES, 12'd0, 24'hFFFFFF, 48'd1040));
      send_req(pack_req(CMD_GLOBAL_BYTES, 12'd0, 24'd2097151, 48'd1041));
      send_req(pack_req(CMD_PEER_PKT, 12'hFFF, 24'd0, 48'hFFFF_FFFF_FFFF));
      send_req(pack_req(CMD_PEER_PKT, 12'hFFF, 24'd0, 48'd3));
      send_req(pack_req(CMD_PEER_BYTES, 12'd2, 24'd0, 48'd0));
      clock_ms = 2000;

      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            drain_wait();
            set_rates(peer_set[ph], global_set[ph]);
         end
         steady = (ph == 2);
         repeat (215) random_req();
         steady = 1'b0;
      end
      drain_wait();
      $display("requests %0d over 7 rate settings incl. zero and full scale:",
               grant_count + deny_count);
      $display("%0d admitted, %0d refused", grant_count, deny_count);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
